// ===== rtl/dlim_pkg.sv =====
// Shared widths, types and a helper function for the three-phase duty limiter.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package dlim_pkg;

    localparam int CMD_W   = 16;                 // phase command width
    localparam int VAL_W   = CMD_W + 1;          // working value, holds +32768
    localparam int MAG_W   = CMD_W;              // magnitude of a working value
    localparam int CFG_W   = 15;                 // register width
    localparam int QUO_W   = CFG_W;              // scaled value is below 2^15
    localparam int PROD_W  = MAG_W + CFG_W;      // full product width
    localparam int REM_W   = MAG_W + CFG_W - 1;  // product is below 2^30
    localparam int DUTY_W  = 16;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int CHK_W   = 19;                 // width of the limit write check

    // Per phase: magnitude stage, multiply stage, divider steps, result stage.
    localparam int PHASE_LAT = QUO_W + 3;
    localparam int LATENCY   = 3 * PHASE_LAT + 1;

    localparam logic [4:0] LIMIT_NUM = 5'd9;
    localparam logic [4:0] LIMIT_DEN = 5'd10;

    typedef enum logic {
        REG_CENTER = 1'b0,
        REG_LIMIT  = 1'b1
    } reg_idx_t;

    typedef logic signed [VAL_W-1:0] val_t;

    // p0 is always the phase that the next check looks at.
    typedef struct packed {
        val_t p0;
        val_t p1;
        val_t p2;
    } vec_t;

    typedef struct packed {
        logic [CFG_W-1:0] center;
        logic [CFG_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic over;
        logic neg0;
        logic neg1;
        logic neg2;
        vec_t x;
    } side_t;

    function automatic logic [MAG_W-1:0] abs_mag(input val_t v);
        return v[VAL_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dlim_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on dlim_pkg for widths, register indexes and cfg_t.
`default_nettype none

module dlim_regs
    import dlim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    reg_idx_t         idx;
    logic             wr_en;
    logic [CFG_W-1:0] wval;
    logic             limit_ok;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1]);
    assign wr_en  = psel & penable & pwrite;
    assign wval   = pwdata[CFG_W-1:0];

    // value < floor(9 * centre / 10) is the same as 10 * (value + 1) <= 9 * centre.
    assign limit_ok = (CHK_W'(wval) * CHK_W'(LIMIT_DEN) + CHK_W'(LIMIT_DEN))
                      <= (CHK_W'(cfg_reg.center) * CHK_W'(LIMIT_NUM));

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_CENTER: cfg_next.center = wval;
                REG_LIMIT:
                begin
                    if (limit_ok)
                    begin
                        cfg_next.limit = wval;
                    end
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CENTER: prdata = DATA_W'(cfg_reg.center);
            REG_LIMIT:  prdata = DATA_W'(cfg_reg.limit);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/dlim_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two dividends
// sharing one divisor. Depends on dlim_pkg for widths and side_t.
`default_nettype none

module dlim_div
    import dlim_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [MAG_W-1:0]            in_mag,
    input  logic [1:0][REM_W-1:0]       in_num,
    input  side_t                       in_side,
    output logic                        out_valid,
    output logic [1:0][QUO_W-1:0]       out_quo,
    output side_t                       out_side
);

    logic [QUO_W-1:0]            valid_reg;
    logic [MAG_W-1:0]            mag_reg  [QUO_W];
    logic [1:0][REM_W-1:0]       rem_reg  [QUO_W];
    logic [1:0][QUO_W-1:0]       quo_reg  [QUO_W];
    side_t                       side_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_step
        localparam int BIT = QUO_W - 1 - s;

        logic                  valid_in;
        logic [MAG_W-1:0]      mag_in;
        logic [1:0][REM_W-1:0] rem_in;
        logic [1:0][QUO_W-1:0] quo_in;
        side_t                 side_in;
        logic [REM_W-1:0]      dsr;
        logic [1:0][REM_W-1:0] rem_next;
        logic [1:0][QUO_W-1:0] quo_next;

        if (s == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign mag_in   = in_mag;
            assign rem_in   = in_num;
            assign quo_in   = '0;
            assign side_in  = in_side;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[s-1];
            assign mag_in   = mag_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign quo_in   = quo_reg[s-1];
            assign side_in  = side_reg[s-1];
        end

        // A MAG_W-bit divisor shifted by at most QUO_W - 1 fits in REM_W bits, so it never overflows.
        assign dsr = REM_W'(mag_in) << BIT;

        always_comb
        begin
            rem_next = rem_in;
            quo_next = quo_in;
            for (int l = 0; l < 2; l++)
            begin
                if (rem_in[l] >= dsr)
                begin
                    rem_next[l]      = rem_in[l] - dsr;
                    quo_next[l][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            mag_reg[s]  <= mag_in;
            rem_reg[s]  <= rem_next;
            quo_reg[s]  <= quo_next;
            side_reg[s] <= side_in;
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/dlim_phase.sv =====
// One limit check: if the leading phase is over the limit, clamps it and scales the other two.
// The output is rotated so the next phase leads. Uses dlim_pkg and dlim_div.
`default_nettype none

module dlim_phase
    import dlim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] limit,
    input  logic             in_valid,
    input  vec_t             in_vec,
    output logic             out_valid,
    output vec_t             out_vec
);

    val_t                   lim_s;

    // Magnitude stage
    side_t                  a_side_next;
    logic                   a_valid_reg;
    side_t                  a_side_reg;
    logic [MAG_W-1:0]       a_mag_reg;
    logic [1:0][MAG_W-1:0]  a_abs_reg;

    // Multiply stage
    logic [1:0][PROD_W-1:0] prod;
    logic [1:0][REM_W-1:0]  b_num_next;
    logic                   b_valid_reg;
    side_t                  b_side_reg;
    logic [MAG_W-1:0]       b_mag_reg;
    logic [1:0][REM_W-1:0]  b_num_reg;

    // Divider output
    logic                   d_valid;
    logic [1:0][QUO_W-1:0]  d_quo;
    side_t                  d_side;

    // Result stage
    val_t                   q1;
    val_t                   q2;
    val_t                   c0;
    vec_t                   c_vec_next;
    logic                   c_valid_reg;
    vec_t                   c_vec_reg;

    assign lim_s = val_t'({2'b00, limit});

    always_comb
    begin
        a_side_next.over = (in_vec.p0 > lim_s) || (in_vec.p0 < -lim_s);
        a_side_next.neg0 = in_vec.p0[VAL_W-1];
        a_side_next.neg1 = in_vec.p1[VAL_W-1];
        a_side_next.neg2 = in_vec.p2[VAL_W-1];
        a_side_next.x    = in_vec;
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            prod[l]       = PROD_W'(a_abs_reg[l]) * PROD_W'(limit);
            b_num_next[l] = prod[l][REM_W-1:0];
        end
    end

    dlim_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_mag    (b_mag_reg),
        .in_num    (b_num_reg),
        .in_side   (b_side_reg),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    // Scaling truncates toward zero, so the sign is applied to the unsigned quotient.
    always_comb
    begin
        q1 = val_t'({2'b00, d_quo[0]});
        q2 = val_t'({2'b00, d_quo[1]});
        if (d_side.neg1)
        begin
            q1 = -q1;
        end
        if (d_side.neg2)
        begin
            q2 = -q2;
        end
        c0 = d_side.neg0 ? -lim_s : lim_s;
        if (d_side.over)
        begin
            c_vec_next.p0 = q1;
            c_vec_next.p1 = q2;
            c_vec_next.p2 = c0;
        end
        else
        begin
            c_vec_next.p0 = d_side.x.p1;
            c_vec_next.p1 = d_side.x.p2;
            c_vec_next.p2 = d_side.x.p0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg   <= a_side_next;
        a_mag_reg    <= abs_mag(in_vec.p0);
        a_abs_reg[0] <= abs_mag(in_vec.p1);
        a_abs_reg[1] <= abs_mag(in_vec.p2);
        b_side_reg   <= a_side_reg;
        b_mag_reg    <= a_mag_reg;
        b_num_reg    <= b_num_next;
        c_vec_reg    <= c_vec_next;
    end

    assign out_valid = c_valid_reg;
    assign out_vec   = c_vec_reg;

endmodule

`default_nettype wire

// ===== rtl/three_phase_duty_limiter_unit.sv =====
// Top level of the three-phase duty limiter: register file, three limit checks
// in series and the duty output register. Depends on dlim_pkg, dlim_regs, dlim_phase.
//
// Usage. A request is taken at a rising edge where start is high and busy is low.
// busy is always low: the pipeline takes a new request in every cycle, one per
// clock sustained, with no gaps needed between requests.
// Each request passes three limit checks (phase a, then b, then c). A check is
// a magnitude stage, a multiply stage, a fifteen-stage restoring divider that
// resolves one quotient bit per stage, and a result stage.
// The duties are then formed as centre plus limited voltage in a final register.
// done is high for exactly one cycle once the request has passed the three checks and the
// duty output register, with duty_a, duty_b and duty_c valid in that cycle; results leave in
// request order. The receiver cannot hold results off, so nothing stalls.
// Registers are written over the APB-style port (centre at 0x0, limit at 0x4);
// they must only change while no request is in flight.
// Reset clears both registers and all pipeline valid flags; requests in flight
// at reset are dropped.
`default_nettype none

module three_phase_duty_limiter_unit
    import dlim_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [CMD_W-1:0]  phase_a_cmd,
    input  logic signed [CMD_W-1:0]  phase_b_cmd,
    input  logic signed [CMD_W-1:0]  phase_c_cmd,
    output logic                     done,
    output logic [DUTY_W-1:0]        duty_a,
    output logic [DUTY_W-1:0]        duty_b,
    output logic [DUTY_W-1:0]        duty_c,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    cfg_t              cfg;
    logic [3:0]        stage_valid;
    vec_t              stage_vec [4];
    logic              done_reg;
    logic [DUTY_W-1:0] duty_a_reg;
    logic [DUTY_W-1:0] duty_b_reg;
    logic [DUTY_W-1:0] duty_c_reg;
    logic [DUTY_W-1:0] duty_a_next;
    logic [DUTY_W-1:0] duty_b_next;
    logic [DUTY_W-1:0] duty_c_next;

    assign busy = 1'b0;

    dlim_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign stage_valid[0]  = start & ~busy;
    assign stage_vec[0].p0 = val_t'(phase_a_cmd);
    assign stage_vec[0].p1 = val_t'(phase_b_cmd);
    assign stage_vec[0].p2 = val_t'(phase_c_cmd);

    // Each check rotates the vector by one place, so after three checks phase a
    // is back in front.
    for (genvar k = 0; k < 3; k++)
    begin : g_phase
        dlim_phase u_phase (
            .clk       (clk),
            .rst_n     (rst_n),
            .limit     (cfg.limit),
            .in_valid  (stage_valid[k]),
            .in_vec    (stage_vec[k]),
            .out_valid (stage_valid[k+1]),
            .out_vec   (stage_vec[k+1])
        );
    end

    // Sums wrap modulo 2^16.
    assign duty_a_next = DUTY_W'(cfg.center) + DUTY_W'(stage_vec[3].p0);
    assign duty_b_next = DUTY_W'(cfg.center) + DUTY_W'(stage_vec[3].p1);
    assign duty_c_next = DUTY_W'(cfg.center) + DUTY_W'(stage_vec[3].p2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid[3];
        end
    end

    always_ff @(posedge clk)
    begin
        duty_a_reg <= duty_a_next;
        duty_b_reg <= duty_b_next;
        duty_c_reg <= duty_c_next;
    end

    assign done   = done_reg;
    assign duty_a = duty_a_reg;
    assign duty_b = duty_b_reg;
    assign duty_c = duty_c_reg;

    // Every request produces its result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not complete after the pipeline latency");

    // No result appears without a request the fixed latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching request");

endmodule

`default_nettype wire

// ===== dv/three_phase_duty_limiter_unit_tb.sv =====
// Self-checking testbench for three_phase_duty_limiter_unit: directed and random
// phase commands under several register settings, checked by a small scoreboard.
// Depends on dlim_pkg and the RTL in rtl/.
`timescale 1ns / 100ps

module three_phase_duty_limiter_unit_tb
    import dlim_pkg::*;
();

    localparam int LIMIT_KEEP_NUM = 9;
    localparam int LIMIT_KEEP_DEN = 10;
    localparam int STALL_LIMIT    = 20 * LATENCY;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 190;

    localparam logic [ADDR_W-1:0] ADDR_CENTER = 3'h0;
    localparam logic [ADDR_W-1:0] ADDR_LIMIT  = 3'h4;

    typedef struct {
        logic [DUTY_W-1:0] a;
        logic [DUTY_W-1:0] b;
        logic [DUTY_W-1:0] c;
    } duty_set_t;

    class duty_scoreboard;
        logic [CFG_W-1:0] center;
        logic [CFG_W-1:0] limit;
        duty_set_t        duty_q[$];
        int               errors;
        int               requests_seen;
        int               results_seen;

        function new();
            center        = '0;
            limit         = '0;
            errors        = 0;
            requests_seen = 0;
            results_seen  = 0;
        endfunction

        function void note_write(reg_idx_t idx, logic [DATA_W-1:0] data);
            int value;
            int threshold;
            value     = int'(data[CFG_W-1:0]);
            threshold = (int'(center) * LIMIT_KEEP_NUM) / LIMIT_KEEP_DEN;
            if (idx == REG_CENTER)
                center = value[CFG_W-1:0];
            else if (value < threshold)
                limit = value[CFG_W-1:0];
        endfunction

        // Phases are checked in order; each check sees what the earlier ones left.
        function void note_request(logic signed [CMD_W-1:0] a, logic signed [CMD_W-1:0] b,
                                   logic signed [CMD_W-1:0] c);
            int        v[3];
            int        lim;
            int        mag;
            int        clamp;
            int        sum;
            bit        over;
            duty_set_t exp_duty;
            v[0] = a;
            v[1] = b;
            v[2] = c;
            lim  = int'(limit);
            for (int k = 0; k < 3; k++)
            begin
                over  = 1'b1;
                mag   = 0;
                clamp = 0;
                if (v[k] > lim)
                begin
                    mag   = v[k];
                    clamp = lim;
                end
                else if (v[k] < -lim)
                begin
                    mag   = -v[k];
                    clamp = -lim;
                end
                else
                    over = 1'b0;
                if (over)
                begin
                    for (int j = 0; j < 3; j++)
                        if (j != k)
                            v[j] = (v[j] * lim) / mag;
                    v[k] = clamp;
                end
            end
            sum = int'(center) + v[0];
            exp_duty.a = sum[DUTY_W-1:0];
            sum = int'(center) + v[1];
            exp_duty.b = sum[DUTY_W-1:0];
            sum = int'(center) + v[2];
            exp_duty.c = sum[DUTY_W-1:0];
            duty_q.push_back(exp_duty);
            requests_seen++;
        endfunction

        function void check_duties(logic [DUTY_W-1:0] a, logic [DUTY_W-1:0] b,
                                   logic [DUTY_W-1:0] c);
            duty_set_t exp_duty;
            results_seen++;
            if (duty_q.size() == 0)
            begin
                $error("duty result with no request outstanding: %0d %0d %0d", a, b, c);
                errors++;
                return;
            end
            exp_duty = duty_q.pop_front();
            if (a !== exp_duty.a)
            begin
                $error("duty_a: expected %0d, actual %0d", exp_duty.a, a);
                errors++;
            end
            if (b !== exp_duty.b)
            begin
                $error("duty_b: expected %0d, actual %0d", exp_duty.b, b);
                errors++;
            end
            if (c !== exp_duty.c)
            begin
                $error("duty_c: expected %0d, actual %0d", exp_duty.c, c);
                errors++;
            end
        endfunction

        function void check_read(reg_idx_t idx, logic [DATA_W-1:0] data);
            logic [DATA_W-1:0] exp_data;
            exp_data = (idx == REG_CENTER) ? DATA_W'(center) : DATA_W'(limit);
            if (data !== exp_data)
            begin
                $error("%s: expected %0d, actual %0d", idx == REG_CENTER ? "center_duty" :
                       "duty_limit", exp_data, data);
                errors++;
            end
        endfunction

        function int pending();
            return duty_q.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [CMD_W-1:0]  phase_a_cmd;
    logic signed [CMD_W-1:0]  phase_b_cmd;
    logic signed [CMD_W-1:0]  phase_c_cmd;
    logic                     done;
    logic [DUTY_W-1:0]        duty_a;
    logic [DUTY_W-1:0]        duty_b;
    logic [DUTY_W-1:0]        duty_c;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    duty_scoreboard sb = new();
    int             settings_used = 0;
    int             stall_count   = 0;

    three_phase_duty_limiter_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .phase_a_cmd (phase_a_cmd),
        .phase_b_cmd (phase_b_cmd),
        .phase_c_cmd (phase_c_cmd),
        .done        (done),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .duty_c      (duty_c),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Everything the block accepts is noted here, at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(phase_a_cmd, phase_b_cmd, phase_c_cmd);
            if (done)
                sb.check_duties(duty_a, duty_b, duty_c);
            if (psel && penable && pready)
            begin
                if (pwrite)
                    sb.note_write(reg_idx_t'(paddr[2]), pwdata);
                else
                    sb.check_read(reg_idx_t'(paddr[2]), prdata);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready) || !rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(input int a, input int b, input int c);
        @(negedge clk);
        start       <= 1'b1;
        phase_a_cmd <= a[CMD_W-1:0];
        phase_b_cmd <= b[CMD_W-1:0];
        phase_c_cmd <= c[CMD_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic apb_transfer(input bit wr, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes are made only once every outstanding request has come back.
    task automatic write_register(input logic [ADDR_W-1:0] addr, input int value);
        logic [DATA_W-1:0] data;
        pause_sender(1);
        while (sb.pending() != 0)
            @(posedge clk);
        data = ($urandom() & 32'hFFFF_8000) | (value & 32'h0000_7FFF);
        apb_transfer(1'b1, addr, data);
        apb_transfer(1'b0, addr, '0);
    endtask

    task automatic set_registers(input int center, input int limit_val);
        write_register(ADDR_CENTER, center);
        write_register(ADDR_LIMIT, limit_val);
        settings_used++;
    endtask

    function automatic int rand_cmd(input int lim);
        logic signed [CMD_W-1:0] raw;
        int                      r;
        int                      pick;
        pick = $urandom_range(0, 3);
        raw  = '0;
        r    = 0;
        case (pick)
            0:
            begin
                raw = CMD_W'($urandom());
                r   = int'(raw);
            end
            1:
            begin
                // Just below, at and just above the limit.
                r = $urandom_range(0, 2);
                r = lim + r - 1;
                if ($urandom_range(0, 1) != 0)
                    r = -r;
            end
            2:
            begin
                r = $urandom_range(0, 2 * lim);
                r = r - lim;
            end
            default:
            begin
                r = $urandom_range(0, 65534);
                r = r - 32767;
            end
        endcase
        return r;
    endfunction

    initial
    begin
        int  center;
        int  limit_val;
        bit  idle_mode;
        rst_n       = 1'b0;
        start       = 1'b0;
        phase_a_cmd = '0;
        phase_b_cmd = '0;
        phase_c_cmd = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: both registers zero, so every phase ends at zero.
        apb_transfer(1'b0, ADDR_CENTER, '0);
        apb_transfer(1'b0, ADDR_LIMIT, '0);
        send_request(1000, -1000, 0);
        send_request(-32768, -32768, -32768);
        send_request(0, 0, 0);
        // With the centre at zero no limit write can be kept.
        write_register(ADDR_LIMIT, 5);

        set_registers(16384, 10000);
        send_request(0, 0, 0);
        send_request(32767, -32767, 32767);
        send_request(-32768, 32767, -1);
        send_request(10000, -10000, 10000);
        send_request(10001, 5000, -5000);
        send_request(-10001, 7000, 9999);
        send_request(3000, 20000, -4000);
        send_request(100, -200, -30000);
        send_request(20000, -15000, 12000);
        send_request(-1, -1, -1);
        send_request(1, -32768, 0);

        // Largest centre; a limit of exactly ninety percent is refused.
        set_registers(32767, 29490);
        write_register(ADDR_LIMIT, 29489);
        send_request(32767, -32768, 29489);
        send_request(-29490, 29490, -29489);

        // A later centre change leaves the limit alone, so duties can go negative.
        set_registers(100, 89);
        write_register(ADDR_CENTER, 0);
        send_request(-32767, 50, -89);
        send_request(-89, -89, -89);
        send_request(-90, 0, 30);

        set_registers(2, 0);
        send_request(5, -5, 0);
        send_request(0, 0, 0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    center    = 32767;
                    limit_val = 29489;
                end
                1:
                begin
                    center    = 32767;
                    limit_val = $urandom_range(0, 40);
                end
                2:
                begin
                    center    = $urandom_range(0, 1);
                    limit_val = $urandom_range(0, 32767);
                end
                default:
                begin
                    center = $urandom_range(0, 32767);
                    if ($urandom_range(0, 3) == 0)
                        limit_val = $urandom_range(0, 32767);
                    else
                        limit_val = $urandom_range(0, (center * LIMIT_KEEP_NUM) /
                                                      LIMIT_KEEP_DEN);
                end
            endcase
            set_registers(center, limit_val);
            idle_mode = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 2) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (idle_mode && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 13));
                send_request(rand_cmd(int'(sb.limit)), rand_cmd(int'(sb.limit)),
                             rand_cmd(int'(sb.limit)));
            end
        end

        pause_sender(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);

        $display("Covered %0d requests and %0d results over %0d register settings,",
                 sb.requests_seen, sb.results_seen, settings_used);
        $display("including clamping at zero limit, the 90%% limit check and duty wrap.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dlim_pkg.sv
rtl/dlim_regs.sv
rtl/dlim_div.sv
rtl/dlim_phase.sv
rtl/three_phase_duty_limiter_unit.sv
dv/three_phase_duty_limiter_unit_tb.sv
